### rtl/sorted_array_list_unit_assert.svh
// Assertion macros used by the file that checks itself.
`ifndef SORTED_ARRAY_LIST_UNIT_ASSERT_SVH
`define SORTED_ARRAY_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SAL_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sal_pkg.sv
package sal_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned ActW        = 2;
  localparam int unsigned CountW      = 5;

  typedef enum logic [ActW-1:0] {
    ActInsert     = 2'd0,
    ActRemove     = 2'd1,
    ActRemoveMin  = 2'd2,
    ActRemoveEven = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StIdle,
    StInsert,
    StCompact
  } state_e;

endpackage

### rtl/sal_ram.sv
module sal_ram import sal_pkg::*; #(
  parameter int unsigned Depth = DefCapacity,
  parameter int unsigned Width = DataW,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sorted_array_list_unit.sv
// An insert into a full list gives its result in the cycle after start; any other
// insert walks StInsert, moving larger entries up, and any removal walks every
// entry in StCompact. One item is worked at a time; the entry RAM, with one read
// and one write port, moves one entry a cycle. The result shows on done_o for one
// cycle and cannot be stalled. Reset empties the list at once; the entry RAM is
// not cleared, as only entries below the count are read.
`include "sorted_array_list_unit_assert.svh"

module sorted_array_list_unit import sal_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [ActW-1:0]         action_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    done_o,
  output logic                    ok_o,
  output logic [CountW-1:0]       count_o,
  output logic                    empty_res_o,
  output logic                    full_res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  state_e             state_q, state_d;
  action_e            act_q, act_d;
  logic [DataW-1:0]   val_q, val_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [IdxW-1:0]    pos_q, pos_d;
  logic [CntW-1:0]    rd_q, rd_d;
  logic [CntW-1:0]    wr_q, wr_d;
  logic               drop_q, drop_d;
  logic               done_q, done_d;
  logic               ok_q, ok_d;

  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [DataW-1:0]   mem_wdata;
  logic [IdxW-1:0]    mem_raddr;
  logic [DataW-1:0]   mem_rdata;
  logic               drop;
  logic               list_full;

  sal_ram #(
    .Depth(CAPACITY),
    .Width(DataW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign list_full = (cnt_q == CntW'(CAPACITY));

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    drop_d    = drop_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = val_q;
    mem_raddr = '0;
    drop      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          act_d = action_e'(action_i);
          val_d = value_i;
          case (action_e'(action_i))
            ActInsert: begin
              if (list_full) begin
                done_d = 1'b1;
                ok_d   = 1'b0;
              end else begin
                // Walk down from the top, moving larger entries up by one.
                pos_d     = IdxW'(cnt_q);
                mem_raddr = IdxW'(cnt_q - 1'b1);
                state_d   = StInsert;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                done_d = 1'b1;
                ok_d   = 1'b0;
              end else begin
                rd_d      = '0;
                wr_d      = '0;
                drop_d    = 1'b0;
                mem_raddr = '0;
                state_d   = StCompact;
              end
            end
          endcase
        end
      end

      StInsert: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        if (pos_q != '0 && $signed(mem_rdata) > $signed(val_q)) begin
          mem_wdata = mem_rdata;
          pos_d     = pos_q - 1'b1;
          mem_raddr = pos_q - IdxW'(2);
        end else begin
          mem_wdata = val_q;
          cnt_d     = cnt_q + 1'b1;
          ok_d      = 1'b1;
          done_d    = 1'b1;
          state_d   = StIdle;
        end
      end

      StCompact: begin
        // Every kept entry is written back at the next free slot below.
        case (act_q)
          ActRemove:    drop = !drop_q && (mem_rdata == val_q);
          ActRemoveMin: drop = (rd_q == '0);
          default:      drop = !mem_rdata[0];
        endcase
        if (!drop) begin
          mem_we    = 1'b1;
          mem_waddr = wr_q[IdxW-1:0];
          mem_wdata = mem_rdata;
          wr_d      = wr_q + 1'b1;
        end
        drop_d    = drop_q | drop;
        rd_d      = rd_q + 1'b1;
        mem_raddr = IdxW'(rd_q + 1'b1);
        if (rd_q == cnt_q - 1'b1) begin
          cnt_d   = drop ? wr_q : wr_q + 1'b1;
          ok_d    = (act_q == ActRemove) ? (drop_q | drop) : 1'b1;
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    val_q  <= val_d;
    pos_q  <= pos_d;
    rd_q   <= rd_d;
    wr_q   <= wr_d;
    drop_q <= drop_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign count_o     = CountW'(cnt_q);
  assign empty_res_o = (cnt_q == '0);
  assign full_res_o  = list_full;

  `SAL_ASSERT(a_count_bound, 1'b1, cnt_q <= CntW'(CAPACITY), "count beyond capacity")
  `SAL_ASSERT(a_fail_keeps_count, done_q && !ok_q, cnt_q == $past(cnt_q),
              "failed item changed the count")
  `SAL_ASSERT(a_insert_grows, done_q && ok_q && act_q == ActInsert,
              cnt_q == CntW'($past(cnt_q) + 1'b1), "insert did not add one entry")
  `SAL_ASSERT_NEXT(a_full_insert_fails,
                   start_i && !busy_o && action_i == ActInsert && list_full,
                   done_q && !ok_q, "insert into a full list not refused at once")

endmodule
